// ----- src/i2c_display_byte_writer_assert.svh -----
// Assertion macros used by the checker file of the display byte writer
`ifndef I2C_DISPLAY_BYTE_WRITER_ASSERT_SVH
`define I2C_DISPLAY_BYTE_WRITER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define IDBW_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("idbw assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low
`define IDBW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("idbw assertion failed");

`endif

// ----- src/idbw_pkg.sv -----
// Shared types and constants for the display byte writer
package idbw_pkg;

	// Input word: bus tick or byte request
	typedef struct packed {
		logic [1:0] command;
		logic [7:0] payload;
	} in_word_t;

	// Output word: pin levels and status after the input word
	typedef struct packed {
		logic scl_level;
		logic sda_level;
		logic busy_res;
		logic accepted;
	} out_word_t;

	// Sequencer request: one input word entering the state update
	typedef struct packed {
		logic     fire;
		in_word_t word;
	} seq_req_t;

	// Command codes
	localparam logic [1:0] CMD_TICK      = 2'd0;
	localparam logic [1:0] CMD_SEND_CMD  = 2'd1;
	localparam logic [1:0] CMD_SEND_DATA = 2'd2;

	// Control bytes following the address
	localparam logic [7:0] CTRL_CMD  = 8'h00;
	localparam logic [7:0] CTRL_DATA = 8'h40;

	// Address register reset value (7-bit address 0x3C plus write bit)
	localparam logic [7:0] ADDR_RESET = 8'h78;

	// Bit counter value of the ninth (acknowledge) clock
	localparam logic [3:0] BIT_ACK = 4'd8;

	// Last phase of a bit slot, last step of start/stop
	localparam logic [1:0] PH_BIT_LAST  = 2'd2;
	localparam logic [1:0] PH_EDGE_LAST = 2'd3;

	// Phase codes within start, stop and bit slots
	localparam logic [1:0] PH_0 = 2'd0;
	localparam logic [1:0] PH_1 = 2'd1;
	localparam logic [1:0] PH_2 = 2'd2;

	// Bus sequence segments
	typedef enum logic [5:0] {
		SEG_IDLE  = 6'b000001,
		SEG_START = 6'b000010,
		SEG_ADDR  = 6'b000100,
		SEG_CTRL  = 6'b001000,
		SEG_DATA  = 6'b010000,
		SEG_STOP  = 6'b100000
	} seg_t;

endpackage

// ----- src/idbw_seq.sv -----
// Bus sequencer: segment, phase and bit counters plus pin levels, one step per tick
module idbw_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  idbw_pkg::seq_req_t    req,
	input  logic [7:0]            addr_byte,
	output idbw_pkg::out_word_t   result
);

	idbw_pkg::seg_t seg_q, seg_d;
	logic [1:0]     ph_q, ph_d;
	logic [3:0]     bit_q, bit_d;
	logic [7:0]     held_q, held_d;
	logic           data_q, data_d;
	logic           scl_q, scl_d;
	logic           sda_q, sda_d;
	logic           acc;
	logic [7:0]     cur_byte;
	logic [2:0]     bit_sel;
	logic           is_req;

	// Byte on the wire in the current segment
	always_comb begin
		unique case (seg_q)
			idbw_pkg::SEG_ADDR: cur_byte = addr_byte;
			idbw_pkg::SEG_CTRL: cur_byte = data_q ? idbw_pkg::CTRL_DATA : idbw_pkg::CTRL_CMD;
			default:            cur_byte = held_q;
		endcase
	end

	// MSB first
	assign bit_sel = ~bit_q[2:0];
	assign is_req  = (req.word.command == idbw_pkg::CMD_SEND_CMD) ||
	                 (req.word.command == idbw_pkg::CMD_SEND_DATA);

	// Next state for the word at the sequencer input
	always_comb begin
		seg_d  = seg_q;
		ph_d   = ph_q;
		bit_d  = bit_q;
		held_d = held_q;
		data_d = data_q;
		scl_d  = scl_q;
		sda_d  = sda_q;
		acc    = 1'b0;
		if (seg_q == idbw_pkg::SEG_IDLE) begin
			// latch a request; pins stay until the first tick
			if (is_req) begin
				held_d = req.word.payload;
				data_d = (req.word.command == idbw_pkg::CMD_SEND_DATA);
				seg_d  = idbw_pkg::SEG_START;
				ph_d   = idbw_pkg::PH_0;
				bit_d  = '0;
				acc    = 1'b1;
			end
		end else if (req.word.command == idbw_pkg::CMD_TICK) begin
			unique case (seg_q) inside
				idbw_pkg::SEG_START: begin
					case (ph_q)
						idbw_pkg::PH_0: sda_d = 1'b1;
						idbw_pkg::PH_1: scl_d = 1'b1;
						idbw_pkg::PH_2: sda_d = 1'b0;
						default:        scl_d = 1'b0;
					endcase
					if (ph_q == idbw_pkg::PH_EDGE_LAST) begin
						seg_d = idbw_pkg::SEG_ADDR;
						ph_d  = idbw_pkg::PH_0;
						bit_d = '0;
					end else begin
						ph_d = ph_q + 2'd1;
					end
				end
				idbw_pkg::SEG_ADDR, idbw_pkg::SEG_CTRL, idbw_pkg::SEG_DATA: begin
					// set SDA, raise SCL, lower SCL; SDA released on the ack clock
					case (ph_q)
						idbw_pkg::PH_0: sda_d = (bit_q == idbw_pkg::BIT_ACK) ? 1'b1
						                                                   : cur_byte[bit_sel];
						idbw_pkg::PH_1: scl_d = 1'b1;
						default:        scl_d = 1'b0;
					endcase
					if (ph_q == idbw_pkg::PH_BIT_LAST) begin
						ph_d = idbw_pkg::PH_0;
						if (bit_q == idbw_pkg::BIT_ACK) begin
							bit_d = '0;
							case (seg_q)
								idbw_pkg::SEG_ADDR: seg_d = idbw_pkg::SEG_CTRL;
								idbw_pkg::SEG_CTRL: seg_d = idbw_pkg::SEG_DATA;
								default:            seg_d = idbw_pkg::SEG_STOP;
							endcase
						end else begin
							bit_d = bit_q + 4'd1;
						end
					end else begin
						ph_d = ph_q + 2'd1;
					end
				end
				idbw_pkg::SEG_STOP: begin
					case (ph_q)
						idbw_pkg::PH_0: scl_d = 1'b0;
						idbw_pkg::PH_1: sda_d = 1'b0;
						idbw_pkg::PH_2: scl_d = 1'b1;
						default:        sda_d = 1'b1;
					endcase
					if (ph_q == idbw_pkg::PH_EDGE_LAST) begin
						seg_d = idbw_pkg::SEG_IDLE;
						ph_d  = idbw_pkg::PH_0;
					end else begin
						ph_d = ph_q + 2'd1;
					end
				end
				default: seg_d = idbw_pkg::SEG_IDLE;
			endcase
		end
	end

	// State update, only when a word passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q  <= idbw_pkg::SEG_IDLE;
			ph_q   <= idbw_pkg::PH_0;
			bit_q  <= '0;
			held_q <= '0;
			data_q <= 1'b0;
			scl_q  <= 1'b1;
			sda_q  <= 1'b1;
		end else if (req.fire) begin
			seg_q  <= seg_d;
			ph_q   <= ph_d;
			bit_q  <= bit_d;
			held_q <= held_d;
			data_q <= data_d;
			scl_q  <= scl_d;
			sda_q  <= sda_d;
		end
	end

	// Result reflects the state after this word
	assign result.scl_level = scl_d;
	assign result.sda_level = sda_d;
	assign result.busy_res  = (seg_d != idbw_pkg::SEG_IDLE);
	assign result.accepted  = acc;

endmodule

// ----- src/i2c_display_byte_writer.sv -----
// Top level of the display byte writer: input register, sequencer, output register
//
//  channel | handshake               | word
//  --------+-------------------------+---------------------------------
//  in      | in_valid / in_stall     | in_word  (command, payload)
//  out     | out_valid / out_stall   | out_word (scl, sda, busy, accepted)
//  cfg     | cfg_we                  | cfg_data (address byte)
//
// One word per cycle sustained while out_stall is low; an accepted word passes
// the input register, then the sequencer update into the output register, and
// then shows at out.
// arst_n clears both stage valids, the sequencer to idle with both lines high,
// and the address register to 0x78.
// While out_stall holds a full output register, the input register holds and
// in_stall rises once it is also full.
module i2c_display_byte_writer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  idbw_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output idbw_pkg::out_word_t out_word,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_data
);

	logic                valid_s1;
	idbw_pkg::in_word_t  word_s1;
	logic                valid_s2;
	idbw_pkg::out_word_t word_s2;
	logic [7:0]          addr_q;
	logic                advance;
	idbw_pkg::seq_req_t  req;
	idbw_pkg::out_word_t seq_result;

	// Address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= idbw_pkg::ADDR_RESET;
		end else if (cfg_we) begin
			addr_q <= cfg_data;
		end
	end

	// Stage 1 moves on when the output register is empty or being drained
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			word_s1 <= in_word;
		end
	end

	// Sequencer
	assign req.fire = valid_s1 && advance;
	assign req.word = word_s1;

	idbw_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.addr_byte (addr_q),
		.result    (seq_result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.fire) begin
			word_s2 <= seq_result;
		end
	end

	assign out_valid = valid_s2;
	assign out_word  = word_s2;

endmodule

// ----- src/idbw_checker.sv -----
// Port-level checker for the display byte writer, bound to the top level
`include "i2c_display_byte_writer_assert.svh"

module idbw_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input idbw_pkg::out_word_t out_word
);

	// A latched request always leaves the block busy
	`IDBW_ASSERT_NOW(a_acc_busy, out_valid && out_word.accepted, out_word.busy_res)

	// Idle bus has both lines released high
	`IDBW_ASSERT_NOW(a_idle_high, out_valid && !out_word.busy_res,
		out_word.scl_level && out_word.sda_level)

	// Input backpressure only comes from a held output word
	`IDBW_ASSERT_NOW(a_stall_src, in_stall, out_valid && out_stall)

	// Stalled output word holds
	`IDBW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

endmodule

bind i2c_display_byte_writer idbw_checker u_idbw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);

// ----- sim/idbw_bus_checker.sv -----
// Scoreboard for the display byte writer: predicts each output word and compares it
module idbw_bus_checker
	import idbw_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_stall,
	input  in_word_t  in_word,
	input  logic      out_valid,
	input  logic      out_stall,
	input  out_word_t out_word,
	input  logic      cfg_we,
	input  logic [7:0] cfg_data,
	output int        mismatches,
	output int        pending
);

	localparam int SEQ_LEN    = 89;
	localparam int START_LEN  = 4;
	localparam int BYTE_LEN   = 27;
	localparam int STOP_BASE  = START_LEN + 3 * BYTE_LEN;

	// Shadow of the block's state
	logic [7:0] addr_reg;
	int         step_no;
	logic [7:0] held_payload;
	logic       data_req;
	logic       scl_q;
	logic       sda_q;

	out_word_t  expected_words[$];
	out_word_t  want;

	initial begin
		mismatches = 0;
		pending    = 0;
	end

	// One line per mismatch, counted
	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_bit(string field, logic got, logic exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("%s got %b, expected %b", field, got, exp_val));
	endtask

	// Applies one input word to the shadow state, returns the output word it causes
	function automatic out_word_t bus_step(in_word_t w);
		out_word_t  r;
		logic       took;
		int         s;
		int         off;
		int         slot;
		int         bitn;
		int         ph;
		logic [7:0] tx;
		took = 1'b0;
		if (step_no > SEQ_LEN)
			step_no = 0;
		case (w.command)
			CMD_TICK: begin
				if (step_no != 0) begin
					s = step_no - 1;
					if (s < START_LEN) begin
						// start condition: SDA falls while SCL is high
						case (s)
							0: sda_q = 1'b1;
							1: scl_q = 1'b1;
							2: sda_q = 1'b0;
							default: scl_q = 1'b0;
						endcase
					end else if (s < STOP_BASE) begin
						// address, control, payload: three steps per bit, MSB first
						off  = s - START_LEN;
						slot = off / BYTE_LEN;
						bitn = (off % BYTE_LEN) / 3;
						ph   = (off % BYTE_LEN) % 3;
						if (slot == 0)
							tx = addr_reg;
						else if (slot == 1)
							tx = data_req ? CTRL_DATA : CTRL_CMD;
						else
							tx = held_payload;
						case (ph)
							PH_0: sda_q = (bitn < BIT_ACK) ? tx[7 - bitn] : 1'b1;
							PH_1: scl_q = 1'b1;
							default: scl_q = 1'b0;
						endcase
					end else begin
						// stop condition: SDA rises while SCL is high
						case (s - STOP_BASE)
							0: scl_q = 1'b0;
							1: sda_q = 1'b0;
							2: scl_q = 1'b1;
							default: sda_q = 1'b1;
						endcase
					end
					step_no = (step_no >= SEQ_LEN) ? 0 : step_no + 1;
				end
			end
			CMD_SEND_CMD, CMD_SEND_DATA: begin
				if (step_no == 0) begin
					held_payload = w.payload;
					data_req     = (w.command == CMD_SEND_DATA);
					step_no      = 1;
					took         = 1'b1;
				end
			end
			default: ;
		endcase
		r.scl_level = scl_q;
		r.sda_level = sda_q;
		r.busy_res  = (step_no != 0);
		r.accepted  = took;
		return r;
	endfunction

	// Watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_reg     = ADDR_RESET;
			step_no      = 0;
			held_payload = 8'h00;
			data_req     = 1'b0;
			scl_q        = 1'b1;
			sda_q        = 1'b1;
			expected_words.delete();
			pending      = 0;
		end else begin
			if (cfg_we)
				addr_reg = cfg_data;
			if (in_valid && !in_stall)
				expected_words.push_back(bus_step(in_word));
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("unexpected word %b", out_word));
				end else begin
					want = expected_words.pop_front();
					check_bit("scl_level", out_word.scl_level, want.scl_level);
					check_bit("sda_level", out_word.sda_level, want.sda_level);
					check_bit("busy_res", out_word.busy_res, want.busy_res);
					check_bit("accepted", out_word.accepted, want.accepted);
				end
			end
			pending = expected_words.size();
		end
	end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the display byte writer: clock, reset, stimulus and verdict
module tb;
	import idbw_pkg::*;

	localparam int          HALF      = 6;
	localparam int          BUS_STEPS = 89;
	localparam int          PHASE_LEN = 570;
	localparam logic [1:0]  CMD_NOP   = 2'd3;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	in_word_t   in_word   = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_word_t  out_word;
	logic       cfg_we    = 1'b0;
	logic [7:0] cfg_data  = 8'h00;

	int          mismatches;
	int          pending;
	int unsigned snd_idle   = 0;
	int unsigned rcv_idle   = 0;
	logic        squeeze    = 1'b0;
	logic        squeezed   = 1'b0;
	int          hold_left  = 0;
	int          steps_left = 0;
	int          items_sent = 0;

	i2c_display_byte_writer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	idbw_bus_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.mismatches(mismatches),
		.pending   (pending)
	);

	always begin
		clk = 1'b0;
		#(HALF);
		clk = 1'b1;
		#(HALF);
	end

	// Receiver: random stalls, plus one long hold-off once squeeze is raised
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (squeeze && !squeezed) begin
			out_stall <= 1'b1;
			hold_left <= 150;
			squeezed  <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_idle);
		end
	end

	// Offer one word, with random gaps ahead of it, and wait until it is taken
	task automatic put_word(in_word_t w);
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Send a word and track where the bus sequence stands
	task automatic offer(logic [1:0] cmd, logic [7:0] pay);
		in_word_t w;
		w.command = cmd;
		w.payload = pay;
		put_word(w);
		items_sent++;
		if (cmd == CMD_TICK && steps_left != 0) begin
			steps_left--;
		end else if ((cmd == CMD_SEND_CMD || cmd == CMD_SEND_DATA) && steps_left == 0) begin
			steps_left = BUS_STEPS;
		end
	endtask

	// Mostly whole transactions; refused requests, no-ops and idle ticks as noise
	task automatic offer_random();
		int unsigned r;
		logic [7:0]  pay;
		logic [1:0]  req;
		r   = $urandom_range(99);
		pay = 8'($urandom_range(255));
		req = $urandom_range(1) ? CMD_SEND_DATA : CMD_SEND_CMD;
		if (r < 4) begin
			offer(CMD_NOP, pay);
		end else if (r < 8) begin
			offer(req, pay);
		end else if (steps_left != 0 || r < 14) begin
			offer(CMD_TICK, pay);
		end else begin
			if ($urandom_range(7) == 0)
				pay = $urandom_range(1) ? 8'hFF : 8'h00;
			offer(req, pay);
		end
	endtask

	// Address write once everything in flight has come out
	task automatic write_addr(logic [7:0] value);
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (2) @(posedge clk);
		cfg_data <= value;
		cfg_we   <= 1'b1;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	task automatic run_phase(int unsigned snd, int unsigned rcv, int n);
		int goal;
		goal     = items_sent + n;
		snd_idle = snd;
		rcv_idle <= rcv;
		while (items_sent < goal)
			offer_random();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: idle tick and no-op, extreme payload, refused requests mid-frame
		offer(CMD_TICK, 8'hFF);
		offer(CMD_NOP, 8'hFF);
		offer(CMD_SEND_CMD, 8'hFF);
		offer(CMD_SEND_DATA, 8'h00);
		offer(CMD_NOP, 8'h00);
		repeat (16) offer(CMD_TICK, 8'h00);
		offer(CMD_SEND_DATA, 8'hAA);

		// Random phases, each with its own address setting
		write_addr(8'hFF);
		run_phase(28, 78, PHASE_LEN);
		write_addr(8'h00);
		run_phase(78, 28, PHASE_LEN);
		write_addr(8'($urandom_range(255)));
		squeeze <= 1'b1;
		run_phase(0, 0, PHASE_LEN);

		// Drain and settle
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// Watchdog
	initial begin
		#(2 * HALF * 400000);
		$display("tb failed");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+src
src/idbw_pkg.sv
src/idbw_seq.sv
src/i2c_display_byte_writer.sv
src/idbw_checker.sv
sim/idbw_bus_checker.sv
sim/tb.sv
